/* design/mbcf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbcf_pkg
// Shared types and constants of the metaball colour field pixel block.
// ----------------------------------------------------------------------------
package mbcf_pkg;

  // ball table depth and derived widths
  localparam int MAX_BALLS = 64;
  localparam int BALL_AW   = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;
  localparam int CNT_W     = $clog2(MAX_BALLS + 1);

  // field widths
  localparam int POS_W  = 13;
  localparam int PIX_W  = 12;
  localparam int DIFF_W = 14;
  localparam int SQ_W   = 26;
  localparam int D2_W   = 27;
  localparam int GAIN_W = 16;
  localparam int CNT_CFG_W = 7;
  localparam int WT_W   = 16;
  localparam int COL_W  = 16;
  localparam int NUM_W  = GAIN_W + WT_W;
  localparam int FRAC_W = 8;
  localparam int PROD_W = NUM_W + COL_W - FRAC_W;
  localparam int ACC_W  = PROD_W + CNT_W;
  localparam int CHAN_W = 8;

  // divider pipeline, one quotient bit per stage
  localparam int DIV_STAGES = NUM_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0]    GAIN_RESET   = GAIN_W'(3000);
  localparam logic [CNT_CFG_W-1:0] ACTIVE_RESET = CNT_CFG_W'(50);
  localparam logic [CHAN_W-1:0]    CHAN_MAX     = CHAN_W'(255);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIELD_GAIN   = 2'd0,
    CFG_ACTIVE_BALLS = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    OP_WRITE_BALL = 1'b0,
    OP_PIXEL      = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // one ball table entry
  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [WT_W-1:0]         size;
    logic [COL_W-1:0]        red;
    logic [COL_W-1:0]        green;
    logic [COL_W-1:0]        blue;
  } ball_entry_t;

  // one ball term travelling through the divider
  typedef struct packed {
    logic             valid;
    logic             last;
    logic             zero;
    logic [D2_W-1:0]  d;
    logic [D2_W-1:0]  rem;
    logic [NUM_W-1:0] nq;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } div_lane_t;

endpackage

/* design/mbcf_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbcf_div
// Pipelined restoring divider: one quotient bit per stage, colour and flags
// carried alongside. Quotient ends in nq of the last stage.
// ----------------------------------------------------------------------------
module mbcf_div
  import mbcf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  div_lane_t div_in,
  output div_lane_t div_out
);

  div_lane_t stage_r  [DIV_STAGES];
  div_lane_t stage_in [DIV_STAGES];

  // one shift, compare and subtract step
  function automatic div_lane_t lane_step(input div_lane_t a);
    logic [D2_W:0] t;
    div_lane_t     b;
    b = a;
    t = {a.rem, a.nq[NUM_W-1]};
    if (t >= {1'b0, a.d}) begin
      b.rem = D2_W'(t - {1'b0, a.d});
      b.nq  = {a.nq[NUM_W-2:0], 1'b1};
    end else begin
      b.rem = t[D2_W-1:0];
      b.nq  = {a.nq[NUM_W-2:0], 1'b0};
    end
    return b;
  endfunction

  // stage inputs
  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        stage_in[k] = div_in;
      end else begin
        stage_in[k] = stage_r[k-1];
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (!rst_n) begin
        stage_r[k].valid <= 1'b0;
      end else begin
        stage_r[k] <= lane_step(stage_in[k]);
      end
    end
  end

  assign div_out = stage_r[DIV_STAGES-1];

endmodule

/* design/metaball_color_field_pixel_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// metaball_color_field_pixel_top
// Ball table plus per-pixel inverse square colour field accumulation.
// ----------------------------------------------------------------------------
// A write beat (op 0) stores one ball entry in the table. A pixel beat (op 1)
// reads the first active_balls entries (capped at the table depth) from the
// table, one entry per cycle through its single read port, and sends each
// through a 32-stage pipelined divider; the next beat is taken once the pixel
// has passed the table read, two setup stages, the divider, the colour
// multiply, the accumulate and the output load. A stalled result holds it
// longer, and with no active balls a pixel goes straight to the output load.
// The result sits in an output register and the block goes back to idle as
// soon as it is loaded there. Items are worked one at a time, so table writes
// never overlap table reads. Table entries read before they are written give
// undefined colours.
// ----------------------------------------------------------------------------
module metaball_color_field_pixel_top
  import mbcf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_op,
  input  logic [5:0]              in_ball_index,
  input  logic signed [POS_W-1:0] in_ball_x,
  input  logic signed [POS_W-1:0] in_ball_y,
  input  logic [WT_W-1:0]         in_ball_size,
  input  logic [COL_W-1:0]        in_ball_red,
  input  logic [COL_W-1:0]        in_ball_green,
  input  logic [COL_W-1:0]        in_ball_blue,
  input  logic [PIX_W-1:0]        in_pixel_x,
  input  logic [PIX_W-1:0]        in_pixel_y,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CHAN_W-1:0]       out_red,
  output logic [CHAN_W-1:0]       out_green,
  output logic [CHAN_W-1:0]       out_blue,
  // configuration channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  state_t state_r, state_nxt;

  logic [GAIN_W-1:0]    field_gain_r;
  logic [CNT_CFG_W-1:0] active_balls_r;

  logic [CNT_W-1:0] count_r, count_nxt, cap_count;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [PIX_W-1:0] px_r, py_r;

  logic start_pix, wr_en, rd_en, issue_last, load_out;

  // table and read port
  ball_entry_t ball_mem [MAX_BALLS];
  ball_entry_t rd_q;
  logic        rd_v_r, rd_last_r;

  // setup stages
  logic              s1_v_r, s1_last_r;
  logic [SQ_W-1:0]   s1_dx2_r, s1_dy2_r;
  logic [NUM_W-1:0]  s1_num_r;
  logic [COL_W-1:0]  s1_red_r, s1_green_r, s1_blue_r;
  logic signed [DIFF_W-1:0]   dx, dy;
  logic signed [2*DIFF_W-1:0] dx_sq, dy_sq;
  div_lane_t         div_in, div_out;

  // multiply stage
  logic              m_v_r, m_last_r;
  logic [2:0]        m_sat_r;
  logic [PROD_W-1:0] m_prod_r [3];
  logic [NUM_W+COL_W-1:0] prod_red, prod_green, prod_blue;

  // accumulators
  logic [ACC_W-1:0] acc_r [3];
  logic [2:0]       sat_r;

  logic              out_valid_r;
  logic [CHAN_W-1:0] out_red_r, out_green_r, out_blue_r;

  // clamp one channel
  function automatic logic [CHAN_W-1:0] clamp_chan(input logic [ACC_W-1:0] acc,
                                                   input logic sat);
    if (sat || (acc[ACC_W-1:FRAC_W] > (ACC_W-FRAC_W)'(CHAN_MAX))) begin
      return CHAN_MAX;
    end
    return acc[FRAC_W+CHAN_W-1:FRAC_W];
  endfunction

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_gain_r   <= GAIN_RESET;
      active_balls_r <= ACTIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_FIELD_GAIN:   field_gain_r   <= cfg_data[GAIN_W-1:0];
        CFG_ACTIVE_BALLS: active_balls_r <= cfg_data[CNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // entry count capped at the table depth
  always_comb begin
    if (int'(active_balls_r) > MAX_BALLS) begin
      cap_count = CNT_W'(MAX_BALLS);
    end else begin
      cap_count = CNT_W'(active_balls_r);
    end
  end

  assign issue_last = (idx_r == (count_r - CNT_W'(1)));

  // control: next state and strobes
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    start_pix = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    load_out  = 1'b0;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (op_t'(in_op) == OP_PIXEL) begin
            start_pix = 1'b1;
            count_nxt = cap_count;
            idx_nxt   = '0;
            state_nxt = (cap_count == '0) ? ST_DONE : ST_RUN;
          end else begin
            wr_en = (int'(in_ball_index) < MAX_BALLS);
          end
        end
      end
      ST_RUN: begin
        rd_en   = 1'b1;
        idx_nxt = idx_r + CNT_W'(1);
        if (issue_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (m_v_r && m_last_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // pixel position of the beat in work
  always_ff @(posedge clk) begin
    if (start_pix) begin
      px_r <= in_pixel_x;
      py_r <= in_pixel_y;
    end
  end

  // ball table: one write or one read a cycle, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ball_mem[BALL_AW'(in_ball_index)] <= '{x: in_ball_x, y: in_ball_y,
                                              size: in_ball_size, red: in_ball_red,
                                              green: in_ball_green,
                                              blue: in_ball_blue};
    end
    if (rd_en) begin
      rd_q <= ball_mem[idx_r[BALL_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= rd_en;
    end
    rd_last_r <= issue_last;
  end

  // stage 1: squared offsets and gain times size
  assign dx    = $signed({2'b00, px_r}) - DIFF_W'(rd_q.x);
  assign dy    = $signed({2'b00, py_r}) - DIFF_W'(rd_q.y);
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= rd_v_r;
    end
    s1_last_r  <= rd_last_r;
    s1_dx2_r   <= dx_sq[SQ_W-1:0];
    s1_dy2_r   <= dy_sq[SQ_W-1:0];
    s1_num_r   <= field_gain_r * rd_q.size;
    s1_red_r   <= rd_q.red;
    s1_green_r <= rd_q.green;
    s1_blue_r  <= rd_q.blue;
  end

  // stage 2: squared distance into the divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_in.valid <= 1'b0;
    end else begin
      div_in.valid <= s1_v_r;
    end
    div_in.last  <= s1_last_r;
    div_in.d     <= D2_W'(s1_dx2_r) + D2_W'(s1_dy2_r);
    div_in.zero  <= (s1_dx2_r == '0) && (s1_dy2_r == '0);
    div_in.rem   <= '0;
    div_in.nq    <= s1_num_r;
    div_in.red   <= s1_red_r;
    div_in.green <= s1_green_r;
    div_in.blue  <= s1_blue_r;
  end

  mbcf_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_in  (div_in),
    .div_out (div_out)
  );

  // colour multiply, zero distance turns into saturation
  assign prod_red   = div_out.nq * div_out.red;
  assign prod_green = div_out.nq * div_out.green;
  assign prod_blue  = div_out.nq * div_out.blue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else begin
      m_v_r <= div_out.valid;
    end
    m_last_r <= div_out.last;
    if (div_out.zero) begin
      m_prod_r[0] <= '0;
      m_prod_r[1] <= '0;
      m_prod_r[2] <= '0;
      m_sat_r     <= {div_out.red != '0, div_out.green != '0, div_out.blue != '0};
    end else begin
      m_prod_r[0] <= prod_red[NUM_W+COL_W-1:FRAC_W];
      m_prod_r[1] <= prod_green[NUM_W+COL_W-1:FRAC_W];
      m_prod_r[2] <= prod_blue[NUM_W+COL_W-1:FRAC_W];
      m_sat_r     <= 3'b000;
    end
  end

  // accumulate per channel, cleared when a pixel starts
  always_ff @(posedge clk) begin
    if (start_pix) begin
      acc_r[0] <= '0;
      acc_r[1] <= '0;
      acc_r[2] <= '0;
      sat_r    <= 3'b000;
    end else if (m_v_r) begin
      acc_r[0] <= acc_r[0] + ACC_W'(m_prod_r[0]);
      acc_r[1] <= acc_r[1] + ACC_W'(m_prod_r[1]);
      acc_r[2] <= acc_r[2] + ACC_W'(m_prod_r[2]);
      sat_r    <= sat_r | m_sat_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (load_out) begin
      out_red_r   <= clamp_chan(acc_r[0], sat_r[2]);
      out_green_r <= clamp_chan(acc_r[1], sat_r[1]);
      out_blue_r  <= clamp_chan(acc_r[2], sat_r[0]);
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

  // a new result only ever follows the done state
  a_rise_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside done state");

  // no ball term may reach the accumulators while idle or done
  a_no_stray_term: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_DONE) |-> !m_v_r)
    else $error("ball term reached accumulators outside a pixel");

  // the last term of a pixel arrives only while draining
  a_last_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (m_v_r && m_last_r) |-> (state_r == ST_DRAIN))
    else $error("last ball term outside drain");

  // a free output register is loaded from the done state at once
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !out_valid_r) |=> out_valid_r)
    else $error("done state did not load the output register");

endmodule
